// ----- rtl/clnws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer: shared package
// Request codes, phase encodings, register indexes and the result record
// that travels from the sequencer core into its output buffer.
// ----------------------------------------------------------------------------
package clnws_pkg;

   // Request codes carried on the cmd field.
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_WRITE_CMD = 3'd1,
      CMD_WRITE_DAT = 3'd2,
      CMD_SET_CUR   = 3'd3,
      CMD_RUN_INIT  = 3'd4
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_INIT_MODE     = 2'd0,
      REG_INIT_FUNCTION = 2'd1,
      REG_INIT_DISPLAY  = 2'd2,
      REG_INIT_CLEAR    = 2'd3
   } reg_index_type;

   // Phase of a byte transfer. Each names the step the next tick performs.
   typedef enum logic [2:0] {
      BP_IDLE       = 3'd0,
      BP_E_RISE_HI  = 3'd1,
      BP_NIBBLE_HI  = 3'd2,
      BP_E_FALL_HI  = 3'd3,
      BP_E_RISE_LO  = 3'd4,
      BP_NIBBLE_LO  = 3'd5,
      BP_E_FALL_LO  = 3'd6,
      BP_FINISH     = 3'd7
   } byte_phase_type;

   // Init sequence position: which init byte is being sent.
   typedef enum logic [2:0] {
      IP_IDLE     = 3'd0,
      IP_MODE     = 3'd1,
      IP_FUNCTION = 3'd2,
      IP_DISPLAY  = 3'd3,
      IP_CLEAR    = 3'd4
   } init_phase_type;

   // Register widths and reset values.
   localparam int unsigned CSR_DATA_W      = 8;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam logic [7:0]  INIT_MODE_RST     = 8'd2;
   localparam logic [7:0]  INIT_FUNCTION_RST = 8'd40;
   localparam logic [7:0]  INIT_DISPLAY_RST  = 8'd12;
   localparam logic [7:0]  INIT_CLEAR_RST    = 8'd1;

   // Set DDRAM address instruction.
   localparam logic [7:0]  SET_CURSOR_BASE = 8'h80;

   // One result transaction.
   typedef struct packed {
      logic       pin_enable;
      logic       pin_register_select;
      logic       pin_read_write;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       byte_done;
      logic       init_done;
      logic       status;
   } rsp_type;

   // DDRAM start address of each display row.
   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] offs;
      unique case (row)
         2'd0:    offs = 8'h00;
         2'd1:    offs = 8'h40;
         2'd2:    offs = 8'h10;
         default: offs = 8'h50;
      endcase
      return offs;
   endfunction

endpackage

// ----- rtl/clnws_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer: result buffer
// Two-entry output buffer (head register plus skid register) so the core
// keeps taking requests while one finished result waits for the receiver.
// ----------------------------------------------------------------------------
module clnws_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  clnws_pkg::rsp_type push_data,
   output logic               can_push,
   output logic               out_valid,
   input  logic               out_ready,
   output clnws_pkg::rsp_type out_data
);

   logic               head_valid_ff, head_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   clnws_pkg::rsp_type head_data_ff, head_data_in;
   clnws_pkg::rsp_type skid_data_ff, skid_data_in;
   logic               pop;

   assign pop       = head_valid_ff && out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_data_ff;

   // Next contents of the head and skid entries.
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_data_in  = head_data_ff;
      skid_data_in  = skid_data_ff;
      if (!head_valid_ff) begin
         head_valid_in = push;
         head_data_in  = push_data;
      end else if (pop) begin
         if (skid_valid_ff) begin
            // Skid entry moves up; no push is possible while it is full.
            head_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // Valid flags are reset; data registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- rtl/char_lcd_nibble_write_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer core
// Loads command, data, cursor and init requests and steps an HD44780-style
// 4-bit write one phase per tick, reporting pin levels after each step.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request or tick per transaction. Every
//   accepted transaction updates the sequencer state and produces exactly one
//   transaction on the rsp_ channel with the pin levels, busy flag, done
//   pulses and the request status (1 when rejected because busy).
//   A byte takes seven ticks after its request: E high, high nibble, E low,
//   E high, low nibble, E low, done. The init request chains four bytes.
//   A result is registered in the output buffer before it is presented.
//   Throughput: one transaction per cycle while req_ready is high; the state
//   update is a single pass of logic from the sequencer registers back into them.
//   A two-entry output buffer holds results when the receiver stalls;
//   req_ready drops only while both entries are full.
//   The csr_ port writes the four init command registers; write only while
//   no results are outstanding.
//   Reset (synchronous) returns the sequencer to idle with the bus low and
//   the init registers at their defaults; the output buffer is emptied.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [7:0]                        req_byte_value,
   input  logic [1:0]                        req_row,
   input  logic [3:0]                        req_col,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pin_enable,
   output logic                              rsp_pin_register_select,
   output logic                              rsp_pin_read_write,
   output logic [3:0]                        rsp_bus_nibble,
   output logic                              rsp_busy_res,
   output logic                              rsp_byte_done,
   output logic                              rsp_init_done,
   output logic                              rsp_status,
   // Configuration port
   input  logic                              csr_we,
   input  logic [clnws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clnws_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Init command registers.
   logic [7:0] init_mode_ff, init_function_ff, init_display_ff, init_clear_ff;

   // Sequencer state.
   clnws_pkg::byte_phase_type byte_phase_ff, byte_phase_in;
   clnws_pkg::init_phase_type init_phase_ff, init_phase_in;
   logic [7:0]                held_byte_ff, held_byte_in;
   logic                      held_select_ff, held_select_in;
   logic                      enable_ff, enable_in;
   logic [3:0]                nibble_ff, nibble_in;

   logic                      accept;
   logic                      busy;
   logic                      done_byte, done_init, status;
   logic [7:0]                init_byte_next;
   logic [7:0]                cursor_addr;
   clnws_pkg::rsp_type        rsp_push, rsp_out;

   assign accept = req_valid && req_ready;
   assign busy   = (byte_phase_ff != clnws_pkg::BP_IDLE) ||
                   (init_phase_ff != clnws_pkg::IP_IDLE);

   // Cursor move instruction: set-address base OR (column + row start).
   assign cursor_addr = clnws_pkg::SET_CURSOR_BASE |
                        ({4'd0, req_col} + clnws_pkg::row_offset(req_row));

   // Init byte that follows the one in flight.
   always_comb begin
      unique case (init_phase_ff)
         clnws_pkg::IP_MODE:     init_byte_next = init_function_ff;
         clnws_pkg::IP_FUNCTION: init_byte_next = init_display_ff;
         default:                init_byte_next = init_clear_ff;
      endcase
   end

   // Next-state logic for one request or tick.
   always_comb begin
      byte_phase_in  = byte_phase_ff;
      init_phase_in  = init_phase_ff;
      held_byte_in   = held_byte_ff;
      held_select_in = held_select_ff;
      enable_in      = enable_ff;
      nibble_in      = nibble_ff;
      done_byte      = 1'b0;
      done_init      = 1'b0;
      status         = 1'b0;
      if (accept) begin
         unique case (req_cmd)
            clnws_pkg::CMD_TICK: begin
               unique case (byte_phase_ff)
                  clnws_pkg::BP_E_RISE_HI: begin
                     enable_in     = 1'b1;
                     byte_phase_in = clnws_pkg::BP_NIBBLE_HI;
                  end
                  clnws_pkg::BP_NIBBLE_HI: begin
                     nibble_in     = held_byte_ff[7:4];
                     byte_phase_in = clnws_pkg::BP_E_FALL_HI;
                  end
                  clnws_pkg::BP_E_FALL_HI: begin
                     enable_in     = 1'b0;
                     byte_phase_in = clnws_pkg::BP_E_RISE_LO;
                  end
                  clnws_pkg::BP_E_RISE_LO: begin
                     enable_in     = 1'b1;
                     byte_phase_in = clnws_pkg::BP_NIBBLE_LO;
                  end
                  clnws_pkg::BP_NIBBLE_LO: begin
                     nibble_in     = held_byte_ff[3:0];
                     byte_phase_in = clnws_pkg::BP_E_FALL_LO;
                  end
                  clnws_pkg::BP_E_FALL_LO: begin
                     enable_in     = 1'b0;
                     byte_phase_in = clnws_pkg::BP_FINISH;
                  end
                  clnws_pkg::BP_FINISH: begin
                     byte_phase_in = clnws_pkg::BP_IDLE;
                     done_byte     = 1'b1;
                     priority if (init_phase_ff == clnws_pkg::IP_MODE ||
                                  init_phase_ff == clnws_pkg::IP_FUNCTION ||
                                  init_phase_ff == clnws_pkg::IP_DISPLAY) begin
                        // Chain the next init byte straight away.
                        init_phase_in  = clnws_pkg::init_phase_type'(init_phase_ff + 3'd1);
                        held_byte_in   = init_byte_next;
                        held_select_in = 1'b0;
                        byte_phase_in  = clnws_pkg::BP_E_RISE_HI;
                     end else if (init_phase_ff != clnws_pkg::IP_IDLE) begin
                        init_phase_in = clnws_pkg::IP_IDLE;
                        done_init     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            clnws_pkg::CMD_WRITE_CMD: begin
               if (busy) begin
                  status = 1'b1;
               end else begin
                  held_byte_in   = req_byte_value;
                  held_select_in = 1'b0;
                  byte_phase_in  = clnws_pkg::BP_E_RISE_HI;
               end
            end
            clnws_pkg::CMD_WRITE_DAT: begin
               if (busy) begin
                  status = 1'b1;
               end else begin
                  held_byte_in   = req_byte_value;
                  held_select_in = 1'b1;
                  byte_phase_in  = clnws_pkg::BP_E_RISE_HI;
               end
            end
            clnws_pkg::CMD_SET_CUR: begin
               if (busy) begin
                  status = 1'b1;
               end else begin
                  held_byte_in   = cursor_addr;
                  held_select_in = 1'b0;
                  byte_phase_in  = clnws_pkg::BP_E_RISE_HI;
               end
            end
            clnws_pkg::CMD_RUN_INIT: begin
               if (busy) begin
                  status = 1'b1;
               end else begin
                  init_phase_in  = clnws_pkg::IP_MODE;
                  held_byte_in   = init_mode_ff;
                  held_select_in = 1'b0;
                  byte_phase_in  = clnws_pkg::BP_E_RISE_HI;
               end
            end
            default: begin
               // Unused request codes change nothing.
            end
         endcase
      end
   end

   // Result fields, taken after this transaction's update.
   always_comb begin
      rsp_push.pin_enable          = enable_in;
      rsp_push.pin_register_select = held_select_in;
      rsp_push.pin_read_write      = 1'b0;
      rsp_push.bus_nibble          = nibble_in;
      rsp_push.busy_res            = (byte_phase_in != clnws_pkg::BP_IDLE) ||
                                     (init_phase_in != clnws_pkg::IP_IDLE);
      rsp_push.byte_done           = done_byte;
      rsp_push.init_done           = done_init;
      rsp_push.status              = status;
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff  <= clnws_pkg::BP_IDLE;
         init_phase_ff  <= clnws_pkg::IP_IDLE;
         held_byte_ff   <= 8'd0;
         held_select_ff <= 1'b0;
         enable_ff      <= 1'b0;
         nibble_ff      <= 4'd0;
      end else begin
         byte_phase_ff  <= byte_phase_in;
         init_phase_ff  <= init_phase_in;
         held_byte_ff   <= held_byte_in;
         held_select_ff <= held_select_in;
         enable_ff      <= enable_in;
         nibble_ff      <= nibble_in;
      end
   end

   // Init command registers written through the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_mode_ff     <= clnws_pkg::INIT_MODE_RST;
         init_function_ff <= clnws_pkg::INIT_FUNCTION_RST;
         init_display_ff  <= clnws_pkg::INIT_DISPLAY_RST;
         init_clear_ff    <= clnws_pkg::INIT_CLEAR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            clnws_pkg::REG_INIT_MODE:     init_mode_ff     <= csr_wdata;
            clnws_pkg::REG_INIT_FUNCTION: init_function_ff <= csr_wdata;
            clnws_pkg::REG_INIT_DISPLAY:  init_display_ff  <= csr_wdata;
            default:                      init_clear_ff    <= csr_wdata;
         endcase
      end
   end

   // Output buffer between the sequencer and the result channel.
   clnws_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_push),
      .can_push  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_pin_enable          = rsp_out.pin_enable;
   assign rsp_pin_register_select = rsp_out.pin_register_select;
   assign rsp_pin_read_write      = rsp_out.pin_read_write;
   assign rsp_bus_nibble          = rsp_out.bus_nibble;
   assign rsp_busy_res            = rsp_out.busy_res;
   assign rsp_byte_done           = rsp_out.byte_done;
   assign rsp_init_done           = rsp_out.init_done;
   assign rsp_status              = rsp_out.status;

endmodule
